@@ design/ahdlc_pkg.sv @@
package ahdlc_pkg;

    localparam int CHANNELS = 2;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] ADDR_BYTE = 8'hFF;
    localparam logic [7:0] CTRL_BYTE = 8'h03;

    localparam logic [1:0] POS_EMPTY = 2'd0;
    localparam logic [1:0] POS_ADDR  = 2'd1;
    localparam logic [1:0] POS_CTRL  = 2'd2;
    localparam logic [1:0] POS_BODY  = 2'd3;

    typedef struct packed {
        logic       escape_pending;
        logic [1:0] frame_position;
        logic       header_all_stripped;
    } t_chan_state;

    typedef struct packed {
        logic       emit;
        logic       out_channel;
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_result;

endpackage

@@ design/ahdlc_core.sv @@
module ahdlc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_channel,
    input  logic [7:0]          i_raw_byte,
    input  logic                i_strip_header,
    output ahdlc_pkg::t_result  o_result
);
    import ahdlc_pkg::*;

    t_chan_state r_state [CHANNELS];
    t_chan_state cur;
    t_chan_state n_cur;
    logic        chan_ok;
    logic        take;
    logic [7:0]  d;
    logic        drop;

    assign chan_ok = ({31'b0, i_channel} < 32'(CHANNELS));
    assign cur     = r_state[i_channel];

    always_comb begin
        n_cur               = cur;
        take                = 1'b0;
        d                   = i_raw_byte;
        drop                = 1'b0;
        o_result.emit        = 1'b0;
        o_result.out_channel = i_channel;
        o_result.frame_byte  = i_raw_byte;
        o_result.frame_end   = 1'b0;

        if (i_raw_byte == FLAG_BYTE) begin
            n_cur.escape_pending = 1'b0;
            if (cur.frame_position != POS_EMPTY) begin
                n_cur.frame_position      = POS_EMPTY;
                n_cur.header_all_stripped = 1'b0;
                o_result.emit             = 1'b1;
                o_result.frame_end        = 1'b1;
            end else begin
                take = 1'b1;
            end
        end else if (cur.escape_pending) begin
            n_cur.escape_pending = 1'b0;
            d    = i_raw_byte ^ ESC_XOR;
            take = 1'b1;
        end else if (i_raw_byte == ESC_BYTE) begin
            n_cur.escape_pending = 1'b1;
        end else begin
            take = 1'b1;
        end

        if (take) begin
            unique case (cur.frame_position)
                POS_EMPTY: drop = i_strip_header && (d == FLAG_BYTE);
                POS_ADDR:  drop = cur.header_all_stripped && (d == ADDR_BYTE);
                POS_CTRL:  drop = cur.header_all_stripped && (d == CTRL_BYTE);
                POS_BODY:  drop = 1'b0;
                default:   drop = 1'b0;
            endcase
            if (cur.frame_position != POS_BODY) begin
                n_cur.header_all_stripped = drop;
                n_cur.frame_position      = cur.frame_position + 2'd1;
            end
            o_result.emit       = !drop;
            o_result.frame_byte = d;
        end

        if (!chan_ok) begin
            o_result.emit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_state[k] <= '0;
            end
        end else if (i_en && chan_ok) begin
            r_state[i_channel] <= n_cur;
        end
    end

endmodule

@@ design/ppp_async_hdlc_deframer.sv @@
// Destuffs PPP asynchronous HDLC bytes for two channels, one byte per clock
// unless the output stalls. Each accepted item passes an input register, a
// per-channel state lookup and update, and an output register, and items
// stream at one per cycle while the output is taken. Escape bytes and
// stripped header bytes give no result. The user must write the strip_header
// register only while the block is idle; the block itself does not enforce it.
module ppp_async_hdlc_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_channel,
    input  logic [7:0] i_raw_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_out_channel,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_end,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);
    import ahdlc_pkg::*;

    logic       r_strip_header;
    logic       r_in_valid;
    logic       r_in_channel;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       r_out_channel;
    logic [7:0] r_out_byte;
    logic       r_out_end;
    logic       advance;
    t_result    result;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    ahdlc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_channel      (r_in_channel),
        .i_raw_byte     (r_in_byte),
        .i_strip_header (r_strip_header),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_header <= 1'b0;
        end else if (i_cfg_we) begin
            r_strip_header <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_channel <= i_channel;
            r_in_byte    <= i_raw_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.emit) begin
            r_out_channel <= result.out_channel;
            r_out_byte    <= result.frame_byte;
            r_out_end     <= result.frame_end;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_frame_byte  = r_out_byte;
    assign o_frame_end   = r_out_end;

endmodule
